// ----- src/tse_pkg.sv -----
// tse_pkg: types and constants shared by the server name extractor modules
// parse phases, status codes, result item and queue write request
// no dependencies
package tse_pkg;

  localparam logic [7:0] CT_HANDSHAKE    = 8'h16;
  localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
  localparam logic [7:0] SNI_TYPE        = 8'h00;
  localparam int         HELLO_FIXED     = 38;
  localparam int         HDR_LEN         = 5;

  // result queue between parser and output side
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [2:0] {
    ST_FOUND      = 3'd0,
    ST_NOSNI      = 3'd1,
    ST_INCOMPLETE = 3'd2,
    ST_NOT_HS     = 3'd3,
    ST_PRE_SSL3   = 3'd4,
    ST_SSL3       = 3'd5,
    ST_NOT_CH     = 3'd6,
    ST_TOO_LONG   = 3'd7
  } status_t;

  typedef enum logic [4:0] {
    PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_HDR4, PH_HS_TYPE, PH_FIX_SKIP,
    PH_SID_LEN, PH_SID_SKIP, PH_CIPH_HI, PH_CIPH_LO, PH_CIPH_SKIP,
    PH_COMP_LEN, PH_COMP_SKIP, PH_EXT_HI, PH_EXT_LO, PH_EH0, PH_EH1,
    PH_EH2_SNI, PH_EH3_SNI, PH_EH2_OTH, PH_EH3_OTH, PH_EXT_SKIP,
    PH_ESKIP, PH_NTYPE, PH_NLEN0_HOST, PH_NLEN1_HOST, PH_NLEN0_OTH,
    PH_NLEN1_OTH, PH_NAME, PH_DONE
  } phase_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] name_char;
    status_t    parse_status;
    logic [7:0] name_length;
    logic       run_end;
  } res_t;

  // up to two results per accepted byte, oldest in it0
  typedef struct packed {
    logic v0;
    logic v1;
    res_t it0;
    res_t it1;
  } wr_req_t;

endpackage

// ----- src/tse_parser.sv -----
// tse_parser: front side, walks the record header, hello fields and extensions
// one payload byte per transfer, emits name byte and status results
// depends on tse_pkg
module tse_parser #(
  parameter int MAX_NAME_BUF = 256,
  parameter int COUNT_WIDTH  = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output tse_pkg::wr_req_t wr
);

  localparam int CW = COUNT_WIDTH;
  localparam int LW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;

  logic [CW-1:0]    byte_count_r, byte_count_nxt;
  tse_pkg::phase_t  phase_r, phase_nxt;
  logic [15:0]      skip_r, skip_nxt;
  logic [15:0]      rec_len_r, rec_len_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [CW-1:0]    ext_end_r, ext_end_nxt;
  logic [15:0]      hname_left_r, hname_left_nxt;
  tse_pkg::status_t verdict_r, verdict_nxt;

  // values after this byte, before the end-of-payload clear
  tse_pkg::phase_t  phase_s;
  logic [15:0]      skip_s;
  logic [15:0]      rec_len_s;
  logic [7:0]       len_hi_s;
  logic [CW-1:0]    ext_end_s;
  logic [15:0]      hname_left_s;
  tse_pkg::status_t verdict_s;

  logic [CW-1:0] cnt;
  logic [LW-1:0] cnt_w, end_w, ext_left_w, n_w, sum_w, new_end_w;
  logic [CW-1:0] new_end;
  logic [15:0]   n16, skip_dec, hname_dec;
  tse_pkg::status_t fin_status;
  tse_pkg::res_t    name_item, stat_item;
  logic             is_name;

  assign cnt        = (byte_count_r != {CW{1'b1}}) ? byte_count_r + 1'b1 : byte_count_r;
  assign cnt_w      = LW'(cnt);
  assign end_w      = LW'(ext_end_r);
  assign ext_left_w = (end_w > cnt_w) ? end_w - cnt_w : '0;
  assign n16        = {len_hi_r, data_byte};
  assign n_w        = LW'(n16);
  assign sum_w      = cnt_w + n_w;
  assign new_end    = (sum_w > LW'({CW{1'b1}})) ? {CW{1'b1}} : sum_w[CW-1:0];
  assign new_end_w  = LW'(new_end);
  assign skip_dec   = skip_r - 16'(skip_r != 16'd0);
  assign hname_dec  = hname_left_r - 16'(hname_left_r != 16'd0);

  // next state of the walk
  always_comb begin
    phase_s      = phase_r;
    skip_s       = skip_r;
    rec_len_s    = rec_len_r;
    len_hi_s     = len_hi_r;
    ext_end_s    = ext_end_r;
    hname_left_s = hname_left_r;
    verdict_s    = verdict_r;
    case (phase_r)
      tse_pkg::PH_HDR0: begin
        if (data_byte != tse_pkg::CT_HANDSHAKE) begin
          phase_s = tse_pkg::PH_DONE; verdict_s = tse_pkg::ST_NOT_HS;
        end else phase_s = tse_pkg::PH_HDR1;
      end
      tse_pkg::PH_HDR1: begin
        if (data_byte < 8'd3) begin
          phase_s = tse_pkg::PH_DONE; verdict_s = tse_pkg::ST_PRE_SSL3;
        end else begin
          len_hi_s = data_byte; phase_s = tse_pkg::PH_HDR2;
        end
      end
      tse_pkg::PH_HDR2: begin
        if (len_hi_r == 8'd3 && data_byte == 8'd0) begin
          phase_s = tse_pkg::PH_DONE; verdict_s = tse_pkg::ST_SSL3;
        end else phase_s = tse_pkg::PH_HDR3;
      end
      tse_pkg::PH_HDR3: begin
        rec_len_s = {data_byte, 8'd0}; phase_s = tse_pkg::PH_HDR4;
      end
      tse_pkg::PH_HDR4: begin
        rec_len_s = {rec_len_r[15:8], data_byte}; phase_s = tse_pkg::PH_HS_TYPE;
      end
      tse_pkg::PH_HS_TYPE: begin
        if (data_byte != tse_pkg::HS_CLIENT_HELLO) begin
          phase_s = tse_pkg::PH_DONE; verdict_s = tse_pkg::ST_NOT_CH;
        end else begin
          skip_s = 16'(tse_pkg::HELLO_FIXED - 1); phase_s = tse_pkg::PH_FIX_SKIP;
        end
      end
      tse_pkg::PH_FIX_SKIP, tse_pkg::PH_SID_SKIP, tse_pkg::PH_CIPH_SKIP,
      tse_pkg::PH_COMP_SKIP, tse_pkg::PH_EXT_SKIP, tse_pkg::PH_ESKIP: begin
        skip_s = skip_dec;
        if (skip_dec == 16'd0) begin
          case (phase_r)
            tse_pkg::PH_FIX_SKIP:  phase_s = tse_pkg::PH_SID_LEN;
            tse_pkg::PH_SID_SKIP:  phase_s = tse_pkg::PH_CIPH_HI;
            tse_pkg::PH_CIPH_SKIP: phase_s = tse_pkg::PH_COMP_LEN;
            tse_pkg::PH_COMP_SKIP: phase_s = tse_pkg::PH_EXT_HI;
            tse_pkg::PH_EXT_SKIP:  phase_s = tse_pkg::PH_EH0;
            default: begin
              // end of the list length or a skipped name entry: another entry type must fit
              if (ext_left_w == '0) begin
                phase_s = tse_pkg::PH_DONE; verdict_s = tse_pkg::ST_INCOMPLETE;
              end else phase_s = tse_pkg::PH_NTYPE;
            end
          endcase
        end
      end
      tse_pkg::PH_SID_LEN: begin
        if (data_byte == 8'd0) phase_s = tse_pkg::PH_CIPH_HI;
        else begin
          skip_s = 16'(data_byte); phase_s = tse_pkg::PH_SID_SKIP;
        end
      end
      tse_pkg::PH_CIPH_HI: begin
        len_hi_s = data_byte; phase_s = tse_pkg::PH_CIPH_LO;
      end
      tse_pkg::PH_CIPH_LO: begin
        if (n16 == 16'd0) phase_s = tse_pkg::PH_COMP_LEN;
        else begin
          skip_s = n16; phase_s = tse_pkg::PH_CIPH_SKIP;
        end
      end
      tse_pkg::PH_COMP_LEN: begin
        if (data_byte == 8'd0) phase_s = tse_pkg::PH_EXT_HI;
        else begin
          skip_s = 16'(data_byte); phase_s = tse_pkg::PH_COMP_SKIP;
        end
      end
      tse_pkg::PH_EXT_HI: phase_s = tse_pkg::PH_EXT_LO;
      tse_pkg::PH_EXT_LO: phase_s = tse_pkg::PH_EH0;
      tse_pkg::PH_EH0: begin
        len_hi_s = data_byte; phase_s = tse_pkg::PH_EH1;
      end
      tse_pkg::PH_EH1: begin
        if (len_hi_r == tse_pkg::SNI_TYPE && data_byte == tse_pkg::SNI_TYPE)
          phase_s = tse_pkg::PH_EH2_SNI;
        else
          phase_s = tse_pkg::PH_EH2_OTH;
      end
      tse_pkg::PH_EH2_SNI: begin
        len_hi_s = data_byte; phase_s = tse_pkg::PH_EH3_SNI;
      end
      tse_pkg::PH_EH2_OTH: begin
        len_hi_s = data_byte; phase_s = tse_pkg::PH_EH3_OTH;
      end
      tse_pkg::PH_EH3_SNI: begin
        if (last_byte) begin
          phase_s = tse_pkg::PH_DONE; verdict_s = tse_pkg::ST_NOSNI;
        end else begin
          ext_end_s = new_end;
          // list length needs two bytes inside the extension
          if (new_end_w <= cnt_w + LW'(1)) begin
            phase_s = tse_pkg::PH_DONE; verdict_s = tse_pkg::ST_INCOMPLETE;
          end else begin
            skip_s = 16'd2; phase_s = tse_pkg::PH_ESKIP;
          end
        end
      end
      tse_pkg::PH_EH3_OTH: begin
        if (last_byte) begin
          phase_s = tse_pkg::PH_DONE; verdict_s = tse_pkg::ST_NOSNI;
        end else if (n16 == 16'd0) phase_s = tse_pkg::PH_EH0;
        else begin
          skip_s = n16; phase_s = tse_pkg::PH_EXT_SKIP;
        end
      end
      tse_pkg::PH_NTYPE: begin
        if (ext_left_w < LW'(2)) begin
          phase_s = tse_pkg::PH_DONE; verdict_s = tse_pkg::ST_INCOMPLETE;
        end else if (data_byte == 8'd0) phase_s = tse_pkg::PH_NLEN0_HOST;
        else phase_s = tse_pkg::PH_NLEN0_OTH;
      end
      tse_pkg::PH_NLEN0_HOST: begin
        len_hi_s = data_byte; phase_s = tse_pkg::PH_NLEN1_HOST;
      end
      tse_pkg::PH_NLEN0_OTH: begin
        len_hi_s = data_byte; phase_s = tse_pkg::PH_NLEN1_OTH;
      end
      tse_pkg::PH_NLEN1_HOST: begin
        if (n_w > ext_left_w) begin
          phase_s = tse_pkg::PH_DONE; verdict_s = tse_pkg::ST_INCOMPLETE;
        end else if (n_w >= LW'(MAX_NAME_BUF - 1)) begin
          phase_s = tse_pkg::PH_DONE; verdict_s = tse_pkg::ST_TOO_LONG;
        end else begin
          skip_s = n16;
          if (n16 == 16'd0) begin
            phase_s = tse_pkg::PH_DONE; verdict_s = tse_pkg::ST_FOUND;
          end else begin
            hname_left_s = n16; phase_s = tse_pkg::PH_NAME;
          end
        end
      end
      tse_pkg::PH_NLEN1_OTH: begin
        if (n_w >= ext_left_w) begin
          phase_s = tse_pkg::PH_DONE; verdict_s = tse_pkg::ST_INCOMPLETE;
        end else if (n16 == 16'd0) begin
          if (ext_left_w == '0) begin
            phase_s = tse_pkg::PH_DONE; verdict_s = tse_pkg::ST_INCOMPLETE;
          end else phase_s = tse_pkg::PH_NTYPE;
        end else begin
          skip_s = n16; phase_s = tse_pkg::PH_ESKIP;
        end
      end
      tse_pkg::PH_NAME: begin
        hname_left_s = hname_dec;
        if (hname_dec == 16'd0) begin
          phase_s = tse_pkg::PH_DONE; verdict_s = tse_pkg::ST_FOUND;
        end
      end
      default: ;
    endcase
  end

  // rearm at the end of each payload
  always_comb begin
    if (last_byte) begin
      byte_count_nxt = '0;
      phase_nxt      = tse_pkg::PH_HDR0;
      skip_nxt       = '0;
      rec_len_nxt    = '0;
      len_hi_nxt     = '0;
      ext_end_nxt    = '0;
      hname_left_nxt = '0;
      verdict_nxt    = tse_pkg::ST_FOUND;
    end else begin
      byte_count_nxt = cnt;
      phase_nxt      = phase_s;
      skip_nxt       = skip_s;
      rec_len_nxt    = rec_len_s;
      len_hi_nxt     = len_hi_s;
      ext_end_nxt    = ext_end_s;
      hname_left_nxt = hname_left_s;
      verdict_nxt    = verdict_s;
    end
  end

  // final status from where the walk stands after this byte
  always_comb begin
    if (cnt_w < LW'(tse_pkg::HDR_LEN))
      fin_status = tse_pkg::ST_INCOMPLETE;
    else if (phase_s == tse_pkg::PH_DONE && (verdict_s == tse_pkg::ST_NOT_HS ||
             verdict_s == tse_pkg::ST_PRE_SSL3 || verdict_s == tse_pkg::ST_SSL3))
      fin_status = verdict_s;
    else if (cnt_w < LW'(rec_len_s) + LW'(tse_pkg::HDR_LEN))
      fin_status = tse_pkg::ST_INCOMPLETE;
    else if (cnt_w < LW'(ext_end_s))
      fin_status = tse_pkg::ST_INCOMPLETE;
    else if (phase_s == tse_pkg::PH_DONE)
      fin_status = verdict_s;
    else if (phase_s == tse_pkg::PH_COMP_SKIP || phase_s == tse_pkg::PH_EXT_HI ||
             (phase_s >= tse_pkg::PH_EH0 && phase_s <= tse_pkg::PH_EXT_SKIP))
      fin_status = tse_pkg::ST_NOSNI;
    else
      fin_status = tse_pkg::ST_INCOMPLETE;
  end

  // result items for this transfer
  always_comb begin
    is_name = (phase_r == tse_pkg::PH_NAME);

    name_item.result_kind  = 1'b0;
    name_item.name_char    = data_byte;
    name_item.parse_status = tse_pkg::ST_FOUND;
    name_item.name_length  = 8'd0;
    name_item.run_end      = 1'b0;

    stat_item.result_kind  = 1'b1;
    stat_item.name_char    = 8'd0;
    stat_item.parse_status = fin_status;
    stat_item.name_length  = (fin_status == tse_pkg::ST_FOUND) ? skip_s[7:0] : 8'd0;
    stat_item.run_end      = 1'b1;

    wr.v0  = accept && (is_name || last_byte);
    wr.v1  = accept && is_name && last_byte;
    wr.it0 = is_name ? name_item : stat_item;
    wr.it1 = stat_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      phase_r      <= tse_pkg::PH_HDR0;
      skip_r       <= '0;
      rec_len_r    <= '0;
      len_hi_r     <= '0;
      ext_end_r    <= '0;
      hname_left_r <= '0;
      verdict_r    <= tse_pkg::ST_FOUND;
    end else if (accept) begin
      byte_count_r <= byte_count_nxt;
      phase_r      <= phase_nxt;
      skip_r       <= skip_nxt;
      rec_len_r    <= rec_len_nxt;
      len_hi_r     <= len_hi_nxt;
      ext_end_r    <= ext_end_nxt;
      hname_left_r <= hname_left_nxt;
      verdict_r    <= verdict_nxt;
    end
  end

  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_byte |=> phase_r == tse_pkg::PH_HDR0 && byte_count_r == '0)
    else $error("parser did not rearm after final byte");

  a_name_needs_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == tse_pkg::PH_NAME |-> hname_left_r != 16'd0)
    else $error("name phase with no bytes left");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    wr.v0 && wr.it0.result_kind |-> last_byte && wr.it0.run_end)
    else $error("status result without final byte");

endmodule

// ----- src/tse_queue.sv -----
// tse_queue: back side, small result queue taking up to two items per transfer
// presents the oldest result on the output side
// depends on tse_pkg
module tse_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  tse_pkg::wr_req_t wr,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output tse_pkg::res_t    head
);

  tse_pkg::res_t             mem_r [tse_pkg::QDEPTH];
  logic [tse_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr1;
  logic [tse_pkg::QCNT_W-1:0] count_r, count_nxt, n_wr;
  logic                       do_pop;

  assign empty   = (count_r == '0);
  // room is kept for a name byte and a status from the same transfer
  assign full    = (count_r > tse_pkg::QCNT_W'(tse_pkg::QDEPTH - 2));
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];
  assign wr_ptr1 = wr_ptr_r + 1'b1;

  always_comb begin
    n_wr       = tse_pkg::QCNT_W'(wr.v0) + tse_pkg::QCNT_W'(wr.v1);
    wr_ptr_nxt = wr_ptr_r + n_wr[tse_pkg::QPTR_W-1:0];
    rd_ptr_nxt = rd_ptr_r + tse_pkg::QPTR_W'(do_pop);
    count_nxt  = count_r + n_wr - tse_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (wr.v0) mem_r[wr_ptr_r] <= wr.it0;
    if (wr.v1) mem_r[wr_ptr1]  <= wr.it1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tse_pkg::QCNT_W'(tse_pkg::QDEPTH))
    else $error("result queue overflow");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr.v0 |-> !full)
    else $error("write into a full queue");

  a_second_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr.v1 |-> wr.v0)
    else $error("second write without first");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    tse_pkg::QPTR_W'(wr_ptr_r - rd_ptr_r) == count_r[tse_pkg::QPTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ----- src/tls_sni_extractor_unit.sv -----
// TLS server name extractor, top level.
// Input channel: one TCP payload byte per transfer (in_push while in_full is
// low), in_last_byte marks the final byte of a payload.
// Result channel: a queue read with out_pop while out_empty is low. Each host
// name byte gives a result with out_result_kind low; the final byte of every
// payload gives one status result (out_result_kind and out_run_end high) with
// the parse status and, when found, the name length.
// Results are registered in the queue and reach the output ports in order, as
// older results are popped.
// Throughput: one byte per cycle while in_full is low; the parser updates
// its walk state on every byte taken. A final byte inside the name gives two
// results, so in_full rises when fewer than two queue slots are free.
// Reset clears the walk state and empties the queue; the parser rearms by
// itself after every final byte. When the receiver stops popping, the four
// entry queue fills and in_full holds off the sender without loss.
// Depends on tse_pkg, tse_parser, tse_queue.
module tls_sni_extractor_unit #(
  parameter int MAX_NAME_BUF = 256,
  parameter int COUNT_WIDTH  = 17
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_result_kind,
  output logic [7:0] out_name_char,
  output logic [2:0] out_parse_status,
  output logic [7:0] out_name_length,
  output logic       out_run_end
);

  tse_pkg::wr_req_t wr;
  tse_pkg::res_t    head;
  logic             q_full;
  logic             in_xfer;

  assign in_full = q_full;
  assign in_xfer = in_push && !q_full;

  tse_parser #(
    .MAX_NAME_BUF (MAX_NAME_BUF),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_xfer),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .wr        (wr)
  );

  tse_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .full  (q_full),
    .empty (out_empty),
    .pop   (out_pop),
    .head  (head)
  );

  assign out_result_kind  = head.result_kind;
  assign out_name_char    = head.name_char;
  assign out_parse_status = head.parse_status;
  assign out_name_length  = head.name_length;
  assign out_run_end      = head.run_end;

endmodule
